[rtl/alcp_pkg.sv]
// ----------------------------------------------------------------------------
// alcp_pkg
// Shared types, widths and constants for the audio level color PWM driver.
// ----------------------------------------------------------------------------
`default_nettype none

package alcp_pkg;

   localparam int STORE_DEPTH = 64;
   localparam int SAMPLE_W    = 10;
   localparam int LEVEL_W     = SAMPLE_W - 1;
   localparam int IDX_W       = $clog2(STORE_DEPTH);
   localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
   localparam int SUM_W       = SAMPLE_W + IDX_W;
   localparam int DCNT_W      = $clog2(SUM_W + 1);

   localparam int WIN_W       = 7;
   localparam int TRIG_W      = 10;
   localparam int RISE_W      = 9;
   localparam int DECAY_W     = 10;
   localparam int PERIOD_W    = 9;
   localparam int CMP_W       = (WIN_W > CNT_W) ? WIN_W : CNT_W;

   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 10;

   localparam int QDEPTH      = 2;
   localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W      = $clog2(QDEPTH + 1);

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LEN     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIGGER_MARGIN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RISE_MARGIN    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_INTERVAL = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PWM_PERIOD     = 3'd4;

   localparam logic [2:0] MODE_R    = 3'd0;
   localparam logic [2:0] MODE_G    = 3'd1;
   localparam logic [2:0] MODE_B    = 3'd2;
   localparam logic [2:0] MODE_RB   = 3'd3;
   localparam logic [2:0] MODE_GB   = 3'd4;
   localparam logic [2:0] MODE_RG   = 3'd5;
   localparam logic [2:0] MODE_RGB  = 3'd6;
   localparam logic [2:0] MODE_LAST = MODE_RGB;

   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_TICK   = 1'b1
   } op_type;

   typedef struct packed {
      logic                cmd;
      logic [SAMPLE_W-1:0] sample;
   } req_type;

   typedef struct packed {
      logic                red_on;
      logic                green_on;
      logic                blue_on;
      logic [LEVEL_W-1:0]  red_duty;
      logic [LEVEL_W-1:0]  green_duty;
      logic [LEVEL_W-1:0]  blue_duty;
      logic [2:0]          color_mode;
      logic [LEVEL_W-1:0]  held_level;
      logic [SAMPLE_W-1:0] block_average;
   } rsp_type;

   typedef struct packed {
      op_type              op;
      logic [SAMPLE_W-1:0] sample;
   } op_item_type;

   typedef struct packed {
      logic [WIN_W-1:0]    window_len;
      logic [TRIG_W-1:0]   trigger_margin;
      logic [RISE_W-1:0]   rise_margin;
      logic [DECAY_W-1:0]  decay_interval;
      logic [PERIOD_W-1:0] pwm_period;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      window_len:     WIN_W'(35),
      trigger_margin: TRIG_W'(10),
      rise_margin:    RISE_W'(15),
      decay_interval: DECAY_W'(300),
      pwm_period:     PERIOD_W'(127)
   };

   // bit 0 red, bit 1 green, bit 2 blue
   function automatic logic [2:0] mode_mask(input logic [2:0] mode);
      logic [2:0] m;
      unique case (mode)
         MODE_R:  m = 3'b001;
         MODE_G:  m = 3'b010;
         MODE_B:  m = 3'b100;
         MODE_RB: m = 3'b101;
         MODE_GB: m = 3'b110;
         MODE_RG: m = 3'b011;
         default: m = 3'b111;
      endcase
      return m;
   endfunction

endpackage

`default_nettype wire

[rtl/alcp_front.sv]
// ----------------------------------------------------------------------------
// alcp_front
// Input queue: accepts items, classifies them as sample or tick.
// ----------------------------------------------------------------------------
`default_nettype none

module alcp_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_push,
   input  wire alcp_pkg::req_type     req_data,
   output logic                       req_full,
   output logic                       op_valid,
   output alcp_pkg::op_item_type      op_item,
   input  wire logic                  op_pop
);

   alcp_pkg::op_item_type                 q_ff [alcp_pkg::QDEPTH];
   logic [alcp_pkg::QPTR_W-1:0]           wr_ptr_ff, wr_ptr_in;
   logic [alcp_pkg::QPTR_W-1:0]           rd_ptr_ff, rd_ptr_in;
   logic [alcp_pkg::QCNT_W-1:0]           cnt_ff, cnt_in;
   alcp_pkg::op_item_type                 new_item;
   logic                                  do_push;
   logic                                  do_pop;

   function automatic logic [alcp_pkg::QPTR_W-1:0] ptr_next(
      input logic [alcp_pkg::QPTR_W-1:0] p);
      logic [alcp_pkg::QPTR_W-1:0] n;
      if (p == alcp_pkg::QPTR_W'(alcp_pkg::QDEPTH - 1)) begin
         n = '0;
      end else begin
         n = p + alcp_pkg::QPTR_W'(1);
      end
      return n;
   endfunction

   assign req_full = (cnt_ff == alcp_pkg::QCNT_W'(alcp_pkg::QDEPTH));
   assign op_valid = (cnt_ff != '0);
   assign op_item  = q_ff[rd_ptr_ff];
   assign do_push  = req_push && !req_full;
   assign do_pop   = op_pop && op_valid;

   always_comb begin
      new_item.op     = req_data.cmd ? alcp_pkg::OP_TICK : alcp_pkg::OP_SAMPLE;
      new_item.sample = req_data.sample;
      wr_ptr_in = do_push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      cnt_in    = cnt_ff + alcp_pkg::QCNT_W'(do_push) - alcp_pkg::QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (do_push) begin
         q_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

`default_nettype wire

[rtl/alcp_back.sv]
// ----------------------------------------------------------------------------
// alcp_back
// Executes samples and ticks: peak hold, decay, color mode, window average
// (sample store sweep plus serial divider) and three-channel PWM.
// ----------------------------------------------------------------------------
`default_nettype none

module alcp_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire alcp_pkg::cfg_type     cfg,
   input  wire logic                  op_valid,
   input  wire alcp_pkg::op_item_type op_item,
   output logic                       op_pop,
   input  wire logic                  rsp_busy,
   output logic                       rsp_push,
   output alcp_pkg::rsp_type          rsp_item
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SUM,
      ST_DIV
   } state_type;

   localparam int SW = alcp_pkg::SAMPLE_W;
   localparam int LW = alcp_pkg::LEVEL_W;
   localparam int DW = alcp_pkg::DECAY_W;
   localparam int PW = alcp_pkg::PERIOD_W;
   localparam int UW = alcp_pkg::SUM_W;
   localparam int CW = alcp_pkg::CNT_W;
   localparam int IW = alcp_pkg::IDX_W;

   state_type                       state_ff, state_in;
   logic                            pend_ff, pend_in;
   logic [IW-1:0]                   wi_ff, wi_in;
   logic [SW-1:0]                   avg_ff, avg_in;
   logic [LW-1:0]                   level_ff, level_in;
   logic [2:0]                      mode_ff, mode_in;
   logic [DW-1:0]                   dc_ff, dc_in;
   logic [PW-1:0]                   tc_ff, tc_in;
   logic [2:0][LW-1:0]              lat_ff, lat_in;
   logic [2:0]                      led_ff, led_in;
   logic [CW-1:0]                   idx_ff, idx_in;
   logic                            rd_vld_ff, rd_vld_in;
   logic [alcp_pkg::DCNT_W-1:0]     dcnt_ff, dcnt_in;
   alcp_pkg::op_item_type           item_ff, item_in;
   logic [UW-1:0]                   sum_ff, sum_in;
   logic [CW-1:0]                   rem_ff, rem_in;

   logic [SW-1:0]                   mem [alcp_pkg::STORE_DEPTH];
   logic [SW-1:0]                   rd_data_ff;
   logic [IW-1:0]                   rd_addr;
   logic                            mem_we;

   logic [CW-1:0]                   len;
   logic [alcp_pkg::CMP_W-1:0]      wl_ext;
   logic [2:0]                      mask;
   logic [2:0][LW-1:0]              tgt;
   logic [DW:0]                     dc_nxt;
   logic                            wrap;
   logic                            peak;
   logic                            raise;
   logic [LW-1:0]                   half;
   logic [LW-1:0]                   lvl_pk;
   logic [CW-1:0]                   wi_nxt;
   logic [PW:0]                     tc_nxt;
   logic                            per_hit;
   logic [PW-1:0]                   tc_new;
   logic [2:0][LW-1:0]              lat_new;
   logic [2:0]                      led_new;
   logic [CW:0]                     shv;
   logic                            ge;
   logic [CW:0]                     diff;
   logic [UW-1:0]                   quo_nxt;

   always_comb begin
      wl_ext = alcp_pkg::CMP_W'(cfg.window_len);
      if (wl_ext == '0) begin
         len = CW'(1);
      end else if (wl_ext > alcp_pkg::CMP_W'(alcp_pkg::STORE_DEPTH)) begin
         len = CW'(alcp_pkg::STORE_DEPTH);
      end else begin
         len = CW'(wl_ext);
      end
   end

   always_comb begin
      mask = alcp_pkg::mode_mask(mode_ff);
      for (int c = 0; c < 3; c++) begin
         tgt[c] = mask[c] ? level_ff : '0;
      end
   end

   always_comb begin
      rsp_item.red_on        = led_ff[0];
      rsp_item.green_on      = led_ff[1];
      rsp_item.blue_on       = led_ff[2];
      rsp_item.red_duty      = tgt[0];
      rsp_item.green_duty    = tgt[1];
      rsp_item.blue_duty     = tgt[2];
      rsp_item.color_mode    = mode_ff;
      rsp_item.held_level    = level_ff;
      rsp_item.block_average = avg_ff;
   end

   // sample path
   always_comb begin
      dc_nxt = {1'b0, dc_ff} + (DW+1)'(1);
      wrap   = dc_nxt > {1'b0, cfg.decay_interval};
      peak   = {1'b0, item_ff.sample} > ({1'b0, avg_ff} + (SW+1)'(cfg.trigger_margin));
      half   = item_ff.sample[SW-1:1];
      raise  = peak && ({1'b0, half} > ({1'b0, level_ff} + (LW+1)'(cfg.rise_margin)));
      lvl_pk = raise ? half : level_ff;
      wi_nxt = CW'(wi_ff) + CW'(1);
   end

   // tick path
   always_comb begin
      tc_nxt  = {1'b0, tc_ff} + (PW+1)'(1);
      per_hit = tc_nxt >= {1'b0, cfg.pwm_period};
      tc_new  = per_hit ? '0 : tc_nxt[PW-1:0];
      for (int c = 0; c < 3; c++) begin
         lat_new[c] = per_hit ? tgt[c] : lat_ff[c];
         led_new[c] = (per_hit && (tgt[c] != '0)) ? 1'b1 : led_ff[c];
         if (lat_new[c] == LW'(tc_new)) begin
            led_new[c] = 1'b0;
         end
      end
   end

   // restoring divide step
   always_comb begin
      shv     = {rem_ff, sum_ff[UW-1]};
      ge      = shv >= (CW+1)'(len);
      diff    = shv - (CW+1)'(len);
      quo_nxt = {sum_ff[UW-2:0], ge};
   end

   assign rd_addr = idx_ff[IW-1:0];

   always_comb begin
      state_in  = state_ff;
      pend_in   = pend_ff;
      wi_in     = wi_ff;
      avg_in    = avg_ff;
      level_in  = level_ff;
      mode_in   = mode_ff;
      dc_in     = dc_ff;
      tc_in     = tc_ff;
      lat_in    = lat_ff;
      led_in    = led_ff;
      idx_in    = idx_ff;
      dcnt_in   = dcnt_ff;
      item_in   = item_ff;
      sum_in    = sum_ff;
      rem_in    = rem_ff;
      rd_vld_in = 1'b0;
      rsp_push  = 1'b0;
      op_pop    = 1'b0;
      mem_we    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (pend_ff && !rsp_busy) begin
               rsp_push = 1'b1;
               pend_in  = 1'b0;
            end
            if (op_valid && (!pend_ff || !rsp_busy)) begin
               op_pop   = 1'b1;
               item_in  = op_item;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (item_ff.op == alcp_pkg::OP_SAMPLE) begin
               mem_we   = 1'b1;
               dc_in    = wrap ? '0 : dc_nxt[DW-1:0];
               level_in = lvl_pk;
               if (wrap) begin
                  if (lvl_pk == '0) begin
                     mode_in = (mode_ff >= alcp_pkg::MODE_LAST) ? alcp_pkg::MODE_R
                                                                : mode_ff + 3'd1;
                  end else begin
                     level_in = lvl_pk - LW'(1);
                  end
               end
               if (wi_nxt >= len) begin
                  wi_in    = '0;
                  idx_in   = '0;
                  sum_in   = '0;
                  state_in = ST_SUM;
               end else begin
                  wi_in    = wi_nxt[IW-1:0];
                  pend_in  = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               tc_in    = tc_new;
               lat_in   = lat_new;
               led_in   = led_new;
               pend_in  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_SUM: begin
            if (rd_vld_ff) begin
               sum_in = sum_ff + UW'(rd_data_ff);
            end
            if (idx_ff == len) begin
               rem_in   = '0;
               dcnt_in  = alcp_pkg::DCNT_W'(UW);
               state_in = ST_DIV;
            end else begin
               rd_vld_in = 1'b1;
               idx_in    = idx_ff + CW'(1);
            end
         end
         ST_DIV: begin
            rem_in  = ge ? diff[CW-1:0] : shv[CW-1:0];
            sum_in  = quo_nxt;
            dcnt_in = dcnt_ff - alcp_pkg::DCNT_W'(1);
            if (dcnt_ff == alcp_pkg::DCNT_W'(1)) begin
               avg_in   = quo_nxt[SW-1:0];
               pend_in  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         pend_ff   <= 1'b0;
         wi_ff     <= '0;
         avg_ff    <= '0;
         level_ff  <= '0;
         mode_ff   <= '0;
         dc_ff     <= '0;
         tc_ff     <= '0;
         lat_ff    <= '0;
         led_ff    <= '0;
         idx_ff    <= '0;
         rd_vld_ff <= 1'b0;
         dcnt_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         pend_ff   <= pend_in;
         wi_ff     <= wi_in;
         avg_ff    <= avg_in;
         level_ff  <= level_in;
         mode_ff   <= mode_in;
         dc_ff     <= dc_in;
         tc_ff     <= tc_in;
         lat_ff    <= lat_in;
         led_ff    <= led_in;
         idx_ff    <= idx_in;
         rd_vld_ff <= rd_vld_in;
         dcnt_ff   <= dcnt_in;
      end
      item_ff <= item_in;
      sum_ff  <= sum_in;
      rem_ff  <= rem_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wi_ff] <= item_ff.sample;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

`default_nettype wire

[rtl/alcp_rsp_reg.sv]
// ----------------------------------------------------------------------------
// alcp_rsp_reg
// Output register holding one finished result until it is popped.
// ----------------------------------------------------------------------------
`default_nettype none

module alcp_rsp_reg (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire alcp_pkg::rsp_type push_data,
   output logic                   busy,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output alcp_pkg::rsp_type      rsp_data
);

   logic              vld_ff, vld_in;
   alcp_pkg::rsp_type data_ff, data_in;

   assign busy      = vld_ff;
   assign rsp_empty = !vld_ff;
   assign rsp_data  = data_ff;

   always_comb begin
      vld_in  = vld_ff;
      data_in = data_ff;
      if (push) begin
         vld_in  = 1'b1;
         data_in = push_data;
      end else if (rsp_pop) begin
         vld_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      data_ff <= data_in;
   end

endmodule

`default_nettype wire

[rtl/audio_level_color_pwm_driver_top.sv]
// ----------------------------------------------------------------------------
// audio_level_color_pwm_driver_top
// Audio peak-level to RGB PWM driver with queue-style item ports.
// ----------------------------------------------------------------------------
// Each item (sample or PWM tick) yields one result. A sample that closes
// the averaging window also averages the sample store, len being the
// effective window length: the store is summed one entry per cycle through
// its single read port, then divided one quotient bit per cycle.
// Up to two items queue at the input and one result waits at the output.
// Registers are written through the csr_ port. The user must write them only
// while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module audio_level_color_pwm_driver_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_push,
   input  wire alcp_pkg::req_type                 req_data,
   output logic                                   req_full,
   output logic                                   rsp_empty,
   input  wire logic                              rsp_pop,
   output alcp_pkg::rsp_type                      rsp_data,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [alcp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [alcp_pkg::CSR_DATA_W-1:0]   csr_data
);

   alcp_pkg::cfg_type     cfg_ff, cfg_in;
   logic                  op_valid;
   alcp_pkg::op_item_type op_item;
   logic                  op_pop;
   logic                  rsp_busy;
   logic                  rsp_push;
   alcp_pkg::rsp_type     rsp_item;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            alcp_pkg::CSR_WINDOW_LEN:
               cfg_in.window_len = csr_data[alcp_pkg::WIN_W-1:0];
            alcp_pkg::CSR_TRIGGER_MARGIN:
               cfg_in.trigger_margin = csr_data[alcp_pkg::TRIG_W-1:0];
            alcp_pkg::CSR_RISE_MARGIN:
               cfg_in.rise_margin = csr_data[alcp_pkg::RISE_W-1:0];
            alcp_pkg::CSR_DECAY_INTERVAL:
               cfg_in.decay_interval = csr_data[alcp_pkg::DECAY_W-1:0];
            alcp_pkg::CSR_PWM_PERIOD:
               cfg_in.pwm_period = csr_data[alcp_pkg::PERIOD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= alcp_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   alcp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .op_valid (op_valid),
      .op_item  (op_item),
      .op_pop   (op_pop)
   );

   alcp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .op_valid (op_valid),
      .op_item  (op_item),
      .op_pop   (op_pop),
      .rsp_busy (rsp_busy),
      .rsp_push (rsp_push),
      .rsp_item (rsp_item)
   );

   alcp_rsp_reg u_rsp (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_item),
      .busy      (rsp_busy),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

[rtl/alcp_checker.sv]
// ----------------------------------------------------------------------------
// alcp_checker
// Port-level assertions for the audio level color PWM driver.
// ----------------------------------------------------------------------------
`default_nettype none

module alcp_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_full,
   input wire logic              rsp_empty,
   input wire logic              rsp_pop,
   input wire alcp_pkg::rsp_type rsp_data
);

   logic [2:0] chk_mask;

   assign chk_mask = alcp_pkg::mode_mask(rsp_data.color_mode);

   a_reset_clean: assert property (@(posedge clock)
      reset |=> (!req_full && rsp_empty))
      else $error("queues not empty after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("waiting result changed");

   a_mode_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.color_mode <= alcp_pkg::MODE_LAST))
      else $error("color mode out of range");

   a_duty_map: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |->
         (rsp_data.red_duty   == (chk_mask[0] ? rsp_data.held_level : '0)) &&
         (rsp_data.green_duty == (chk_mask[1] ? rsp_data.held_level : '0)) &&
         (rsp_data.blue_duty  == (chk_mask[2] ? rsp_data.held_level : '0)))
      else $error("duties disagree with mode and level");

endmodule

bind audio_level_color_pwm_driver_top alcp_checker u_alcp_checker (.*);

`default_nettype wire
